// ===== rtl/cmta_pkg.sv =====
package cmta_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int FRACTION_BITS  = 16;
    localparam int MAX_FACE_SIZE  = 4096;

    localparam int SIZE_BITS      = 13;
    localparam int INDEX_BITS     = 12;
    localparam int FACE_BITS      = 3;
    localparam int NUM_BITS       = COMPONENT_BITS + 1;
    localparam int REM_BITS       = COMPONENT_BITS + 1;
    localparam int SCALE_BITS     = $clog2(MAX_FACE_SIZE + 1);
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = SIZE_BITS;
    localparam int SIZE_RESET     = 512;

    localparam logic [FACE_BITS-1:0] FACE_POS_X = FACE_BITS'(0);
    localparam logic [FACE_BITS-1:0] FACE_NEG_X = FACE_BITS'(1);
    localparam logic [FACE_BITS-1:0] FACE_POS_Y = FACE_BITS'(2);
    localparam logic [FACE_BITS-1:0] FACE_NEG_Y = FACE_BITS'(3);
    localparam logic [FACE_BITS-1:0] FACE_POS_Z = FACE_BITS'(4);
    localparam logic [FACE_BITS-1:0] FACE_NEG_Z = FACE_BITS'(5);

    localparam logic [CFG_INDEX_BITS-1:0] REG_FACE_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FACE_HEIGHT = CFG_INDEX_BITS'(1);

    typedef struct packed {
        logic                      zero;
        logic [FACE_BITS-1:0]      face;
        logic [COMPONENT_BITS-1:0] mag;
        logic [NUM_BITS-1:0]       num_u;
        logic [NUM_BITS-1:0]       num_v;
    } t_sel_word;

    typedef struct packed {
        logic                     zero;
        logic [FACE_BITS-1:0]     face;
        logic [REM_BITS-1:0]      divisor;
        logic [REM_BITS-1:0]      rem_u;
        logic [REM_BITS-1:0]      rem_v;
        logic [FRACTION_BITS-1:0] quo_u;
        logic [FRACTION_BITS-1:0] quo_v;
    } t_cell_word;

    function automatic logic [SCALE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] s);
        if (32'(s) > MAX_FACE_SIZE) begin
            return SCALE_BITS'(MAX_FACE_SIZE);
        end
        return SCALE_BITS'(s);
    endfunction

endpackage

// ===== rtl/cmta_front.sv =====
module cmta_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic [cmta_pkg::COMPONENT_BITS-1:0]   i_dir_x,
    input  logic [cmta_pkg::COMPONENT_BITS-1:0]   i_dir_y,
    input  logic [cmta_pkg::COMPONENT_BITS-1:0]   i_dir_z,
    output logic                                  o_ready,
    output logic                                  o_valid,
    output cmta_pkg::t_cell_word                  o_word,
    input  logic                                  i_ready
);

    localparam int C = cmta_pkg::COMPONENT_BITS;
    localparam int N = cmta_pkg::NUM_BITS;

    logic [C-1:0] ax, ay, az;
    logic [N-1:0] ex, ey, ez, nx, nz;
    logic         sel_x, sel_y, z_pos;
    cmta_pkg::t_sel_word n_sel;
    cmta_pkg::t_sel_word r_sel;
    logic         r_sel_valid;
    logic         sel_ready;

    cmta_pkg::t_cell_word n_cell;
    cmta_pkg::t_cell_word r_cell;
    logic         r_cell_valid;

    logic [N:0]   t_u_full, t_v_full;
    logic [cmta_pkg::REM_BITS-1:0] t_u, t_v, div;

    always_comb begin
        ax = i_dir_x[C-1] ? (~i_dir_x + 1'b1) : i_dir_x;
        ay = i_dir_y[C-1] ? (~i_dir_y + 1'b1) : i_dir_y;
        az = i_dir_z[C-1] ? (~i_dir_z + 1'b1) : i_dir_z;
        ex = {i_dir_x[C-1], i_dir_x};
        ey = {i_dir_y[C-1], i_dir_y};
        ez = {i_dir_z[C-1], i_dir_z};
        nx = ~ex + 1'b1;
        nz = ~ez + 1'b1;
        sel_x = (ax > ay) && (ax > az);
        sel_y = !sel_x && (ay > az);
        z_pos = !i_dir_z[C-1] && (|i_dir_z);

        n_sel.zero = (i_dir_x == '0) && (i_dir_y == '0) && (i_dir_z == '0);
        if (sel_x) begin
            n_sel.mag = ax;
            if (!i_dir_x[C-1]) begin
                n_sel.face  = cmta_pkg::FACE_POS_X;
                n_sel.num_u = ez;
                n_sel.num_v = ey;
            end else begin
                n_sel.face  = cmta_pkg::FACE_NEG_X;
                n_sel.num_u = nz;
                n_sel.num_v = ey;
            end
        end else if (sel_y) begin
            n_sel.mag = ay;
            if (!i_dir_y[C-1]) begin
                n_sel.face  = cmta_pkg::FACE_POS_Y;
                n_sel.num_u = ex;
                n_sel.num_v = ez;
            end else begin
                n_sel.face  = cmta_pkg::FACE_NEG_Y;
                n_sel.num_u = ex;
                n_sel.num_v = nz;
            end
        end else begin
            n_sel.mag = az;
            if (z_pos) begin
                n_sel.face  = cmta_pkg::FACE_POS_Z;
                n_sel.num_u = nx;
                n_sel.num_v = ey;
            end else begin
                n_sel.face  = cmta_pkg::FACE_NEG_Z;
                n_sel.num_u = ex;
                n_sel.num_v = ey;
            end
        end
    end

    // t = n + m lies in [0, 2m]; t == 2m is the wrapped 1.0 and restarts at 0
    always_comb begin
        t_u_full = {r_sel.num_u[N-1], r_sel.num_u} + {2'b00, r_sel.mag};
        t_v_full = {r_sel.num_v[N-1], r_sel.num_v} + {2'b00, r_sel.mag};
        t_u      = t_u_full[cmta_pkg::REM_BITS-1:0];
        t_v      = t_v_full[cmta_pkg::REM_BITS-1:0];
        div      = {r_sel.mag, 1'b0};

        n_cell.zero    = r_sel.zero;
        n_cell.face    = r_sel.face;
        n_cell.divisor = div;
        n_cell.rem_u   = (t_u == div) ? '0 : t_u;
        n_cell.rem_v   = (t_v == div) ? '0 : t_v;
        n_cell.quo_u   = '0;
        n_cell.quo_v   = '0;
    end

    assign o_ready   = !r_sel_valid || sel_ready;
    assign sel_ready = !r_cell_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_valid  <= 1'b0;
            r_cell_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_sel_valid <= i_valid;
            end
            if (sel_ready) begin
                r_cell_valid <= r_sel_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_sel <= n_sel;
        end
        if (sel_ready) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_cell_valid;
    assign o_word  = r_cell;

endmodule

// ===== rtl/cmta_div_cell.sv =====
module cmta_div_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  cmta_pkg::t_cell_word i_word,
    output logic                 o_ready,
    output logic                 o_valid,
    output cmta_pkg::t_cell_word o_word,
    input  logic                 i_ready
);

    localparam int R = cmta_pkg::REM_BITS;
    localparam int F = cmta_pkg::FRACTION_BITS;

    logic [R:0]   d_ext, u2, v2, u_diff, v_diff;
    logic         u_ge, v_ge;
    cmta_pkg::t_cell_word n_word;
    cmta_pkg::t_cell_word r_word;
    logic         r_valid;

    // one restoring quotient bit per cell for both coordinates
    always_comb begin
        d_ext  = {1'b0, i_word.divisor};
        u2     = {i_word.rem_u, 1'b0};
        v2     = {i_word.rem_v, 1'b0};
        u_diff = u2 - d_ext;
        v_diff = v2 - d_ext;
        u_ge   = u2 >= d_ext;
        v_ge   = v2 >= d_ext;

        n_word       = i_word;
        n_word.rem_u = u_ge ? u_diff[R-1:0] : u2[R-1:0];
        n_word.rem_v = v_ge ? v_diff[R-1:0] : v2[R-1:0];
        n_word.quo_u = {i_word.quo_u[F-2:0], u_ge};
        n_word.quo_v = {i_word.quo_v[F-2:0], v_ge};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== rtl/cmta_scale.sv =====
module cmta_scale (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  cmta_pkg::t_cell_word                i_word,
    input  logic [cmta_pkg::SIZE_BITS-1:0]      i_face_width,
    input  logic [cmta_pkg::SIZE_BITS-1:0]      i_face_height,
    output logic                                o_ready,
    output logic                                o_valid,
    output logic [cmta_pkg::FACE_BITS-1:0]      o_face,
    output logic [cmta_pkg::INDEX_BITS-1:0]     o_texel_col,
    output logic [cmta_pkg::INDEX_BITS-1:0]     o_texel_row,
    output logic                                o_zero_direction,
    input  logic                                i_stall
);

    localparam int F = cmta_pkg::FRACTION_BITS;
    localparam int S = cmta_pkg::SCALE_BITS;
    localparam int I = cmta_pkg::INDEX_BITS;

    logic [S-1:0]   s_w, s_h;
    logic [F+S-1:0] prod_u, prod_v;
    logic           r_valid;
    logic [cmta_pkg::FACE_BITS-1:0] r_face;
    logic [I-1:0]   r_col, r_row;
    logic           r_zero;

    always_comb begin
        s_w    = cmta_pkg::clamp_size(i_face_width);
        s_h    = cmta_pkg::clamp_size(i_face_height);
        prod_u = {{S{1'b0}}, i_word.quo_u} * {{F{1'b0}}, s_w};
        prod_v = {{S{1'b0}}, i_word.quo_v} * {{F{1'b0}}, s_h};
    end

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_face <= i_word.zero ? cmta_pkg::FACE_NEG_Z : i_word.face;
            r_col  <= i_word.zero ? '0 : prod_u[F +: I];
            r_row  <= i_word.zero ? '0 : prod_v[F +: I];
            r_zero <= i_word.zero;
        end
    end

    assign o_valid          = r_valid;
    assign o_face           = r_face;
    assign o_texel_col      = r_col;
    assign o_texel_row      = r_row;
    assign o_zero_direction = r_zero;

endmodule

// ===== rtl/cubemap_texel_address_unit.sv =====
// Cube map face selection and texel addressing. One direction word is taken
// per clock and one result word leaves per clock when not stalled. It has
// two front stages (face select, then offset), a chain of 16 divider cells
// producing one fraction bit of u and v each, and one scaling stage with
// the output register. Any empty stage lets a new word in while the output
// is stalled. Face width and height must be written through the config
// port only while no word is in flight; the block does not enforce this.
module cubemap_texel_address_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [cmta_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [cmta_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [cmta_pkg::COMPONENT_BITS-1:0]   i_dir_x,
    input  logic [cmta_pkg::COMPONENT_BITS-1:0]   i_dir_y,
    input  logic [cmta_pkg::COMPONENT_BITS-1:0]   i_dir_z,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [cmta_pkg::FACE_BITS-1:0]        o_face,
    output logic [cmta_pkg::INDEX_BITS-1:0]       o_texel_col,
    output logic [cmta_pkg::INDEX_BITS-1:0]       o_texel_row,
    output logic                                  o_zero_direction
);

    localparam int F = cmta_pkg::FRACTION_BITS;

    logic [cmta_pkg::SIZE_BITS-1:0] r_face_width, r_face_height;

    cmta_pkg::t_cell_word w_word  [0:F];
    logic                 w_valid [0:F];
    logic                 w_ready [0:F];
    logic                 front_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_width  <= cmta_pkg::SIZE_BITS'(cmta_pkg::SIZE_RESET);
            r_face_height <= cmta_pkg::SIZE_BITS'(cmta_pkg::SIZE_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cmta_pkg::REG_FACE_WIDTH: begin
                    r_face_width <= i_cfg_data;
                end
                cmta_pkg::REG_FACE_HEIGHT: begin
                    r_face_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    cmta_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_dir_x (i_dir_x),
        .i_dir_y (i_dir_y),
        .i_dir_z (i_dir_z),
        .o_ready (front_ready),
        .o_valid (w_valid[0]),
        .o_word  (w_word[0]),
        .i_ready (w_ready[0])
    );

    for (genvar k = 0; k < F; k++) begin : g_cell
        cmta_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .i_word  (w_word[k]),
            .o_ready (w_ready[k]),
            .o_valid (w_valid[k+1]),
            .o_word  (w_word[k+1]),
            .i_ready (w_ready[k+1])
        );
    end

    cmta_scale u_scale (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_valid[F]),
        .i_word           (w_word[F]),
        .i_face_width     (r_face_width),
        .i_face_height    (r_face_height),
        .o_ready          (w_ready[F]),
        .o_valid          (o_valid),
        .o_face           (o_face),
        .o_texel_col      (o_texel_col),
        .o_texel_row      (o_texel_row),
        .o_zero_direction (o_zero_direction),
        .i_stall          (i_stall)
    );

    assign o_stall = !front_ready;

    a_empty_out_never_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output register");

    a_zero_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_direction) |-> (o_face == cmta_pkg::FACE_NEG_Z))
        else $error("zero direction not on negative z face");

    a_zero_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_direction) |-> (o_texel_col == '0 && o_texel_row == '0))
        else $error("zero direction with non-zero texel address");

    a_face_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_face <= cmta_pkg::FACE_NEG_Z))
        else $error("face index out of range");

endmodule

// ===== tb/tb_cubemap_texel_address_unit.sv =====
`timescale 1ns / 100ps

module tb_cubemap_texel_address_unit;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 25;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 100;

    typedef struct {
        logic signed [cmta_pkg::COMPONENT_BITS-1:0] x;
        logic signed [cmta_pkg::COMPONENT_BITS-1:0] y;
        logic signed [cmta_pkg::COMPONENT_BITS-1:0] z;
    } t_direction;

    typedef struct {
        logic [cmta_pkg::FACE_BITS-1:0]  face;
        logic [cmta_pkg::INDEX_BITS-1:0] col;
        logic [cmta_pkg::INDEX_BITS-1:0] row;
        logic                            zero;
    } t_texel_addr;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [cmta_pkg::CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [cmta_pkg::CFG_DATA_BITS-1:0]  i_cfg_data = '0;
    logic                                i_valid = 1'b0;
    logic                                o_stall;
    logic [cmta_pkg::COMPONENT_BITS-1:0] i_dir_x = '0;
    logic [cmta_pkg::COMPONENT_BITS-1:0] i_dir_y = '0;
    logic [cmta_pkg::COMPONENT_BITS-1:0] i_dir_z = '0;
    logic                                o_valid;
    logic                                i_stall = 1'b0;
    logic [cmta_pkg::FACE_BITS-1:0]      o_face;
    logic [cmta_pkg::INDEX_BITS-1:0]     o_texel_col;
    logic [cmta_pkg::INDEX_BITS-1:0]     o_texel_row;
    logic                                o_zero_direction;

    t_direction  direction_q[$];
    t_texel_addr address_q[$];

    int unsigned face_width_cfg  = cmta_pkg::SIZE_RESET;
    int unsigned face_height_cfg = cmta_pkg::SIZE_RESET;
    int          send_idle_pct   = 0;
    int          recv_stall_pct  = 0;
    int          hold_asks       = 0;
    int          hold_seen       = 0;
    int          hold_left       = 0;
    int          mismatch_count  = 0;
    int          cycle_count     = 0;

    int send_plan[PHASES]   = '{0, 58, 0, 36, 0, 58, 36};
    int recv_plan[PHASES]   = '{0, 0, 58, 36, 0, 58, 36};
    int width_plan[PHASES]  = '{1, 4096, 8191, 0, 640, 0, 0};
    int height_plan[PHASES] = '{1, 4096, 0, 4097, 480, 0, 0};

    cubemap_texel_address_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_dir_x          (i_dir_x),
        .i_dir_y          (i_dir_y),
        .i_dir_z          (i_dir_z),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_face           (o_face),
        .o_texel_col      (o_texel_col),
        .o_texel_row      (o_texel_row),
        .o_zero_direction (o_zero_direction)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // (n/m + 1)/2 in fixed point, integer part dropped, then scaled and floored
    function automatic longint scaled_index(longint n, longint m, int unsigned size);
        longint w;
        longint s;
        w = ((n + m) << cmta_pkg::FRACTION_BITS) / (2 * m);
        w = w & ((longint'(1) << cmta_pkg::FRACTION_BITS) - 1);
        s = (size > cmta_pkg::MAX_FACE_SIZE) ? cmta_pkg::MAX_FACE_SIZE : size;
        return ((w * s) >> cmta_pkg::FRACTION_BITS)
               & ((longint'(1) << cmta_pkg::INDEX_BITS) - 1);
    endfunction

    function automatic t_texel_addr cube_address(t_direction d);
        longint      x, y, z, ax, ay, az, m, nu, nv;
        t_texel_addr r;
        x  = d.x;
        y  = d.y;
        z  = d.z;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        r.zero = 1'b0;
        if (x == 0 && y == 0 && z == 0) begin
            r.face = cmta_pkg::FACE_NEG_Z;
            r.col  = '0;
            r.row  = '0;
            r.zero = 1'b1;
            return r;
        end
        if (ax > ay && ax > az) begin
            m = ax;
            if (x > 0) begin
                r.face = cmta_pkg::FACE_POS_X; nu = z;  nv = y;
            end else begin
                r.face = cmta_pkg::FACE_NEG_X; nu = -z; nv = y;
            end
        end else if (ay > az) begin
            m = ay;
            if (y > 0) begin
                r.face = cmta_pkg::FACE_POS_Y; nu = x; nv = z;
            end else begin
                r.face = cmta_pkg::FACE_NEG_Y; nu = x; nv = -z;
            end
        end else begin
            m = az;
            if (z > 0) begin
                r.face = cmta_pkg::FACE_POS_Z; nu = -x; nv = y;
            end else begin
                r.face = cmta_pkg::FACE_NEG_Z; nu = x;  nv = y;
            end
        end
        r.col = cmta_pkg::INDEX_BITS'(scaled_index(nu, m, face_width_cfg));
        r.row = cmta_pkg::INDEX_BITS'(scaled_index(nv, m, face_height_cfg));
        return r;
    endfunction

    function automatic void push_dir(int x, int y, int z);
        t_direction d;
        d.x = cmta_pkg::COMPONENT_BITS'(x);
        d.y = cmta_pkg::COMPONENT_BITS'(y);
        d.z = cmta_pkg::COMPONENT_BITS'(z);
        direction_q.push_back(d);
    endfunction

    // mix of full-range, tiny, tied and partly zero vectors
    function automatic t_direction random_direction();
        t_direction d;
        d.x = cmta_pkg::COMPONENT_BITS'($urandom);
        d.y = cmta_pkg::COMPONENT_BITS'($urandom);
        d.z = cmta_pkg::COMPONENT_BITS'($urandom);
        case ($urandom_range(3))
            1: begin
                d.x = cmta_pkg::COMPONENT_BITS'(int'($urandom_range(6)) - 3);
                d.y = cmta_pkg::COMPONENT_BITS'(int'($urandom_range(6)) - 3);
                d.z = cmta_pkg::COMPONENT_BITS'(int'($urandom_range(6)) - 3);
            end
            2: begin
                case ($urandom_range(2))
                    0: d.y = $urandom_range(1) ? d.x : -d.x;
                    1: d.z = $urandom_range(1) ? d.y : -d.y;
                    default: d.z = $urandom_range(1) ? d.x : -d.x;
                endcase
            end
            3: begin
                if ($urandom_range(1)) d.x = '0;
                if ($urandom_range(1)) d.y = '0;
                if ($urandom_range(1)) d.z = '0;
            end
            default: ;
        endcase
        return d;
    endfunction

    task automatic write_reg(logic [cmta_pkg::CFG_INDEX_BITS-1:0] idx,
                             logic [cmta_pkg::CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx == cmta_pkg::REG_FACE_WIDTH) face_width_cfg = data;
        else if (idx == cmta_pkg::REG_FACE_HEIGHT) face_height_cfg = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait for every pending word to be sent and every result to arrive
    task automatic settle();
        @(negedge i_clk);
        while (direction_q.size() != 0 || i_valid || address_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : drive
        t_direction nxt;
        logic       busy;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            busy = i_valid;
            if (i_valid && !o_stall) begin
                nxt.x = i_dir_x;
                nxt.y = i_dir_y;
                nxt.z = i_dir_z;
                address_q.push_back(cube_address(nxt));
                busy = 1'b0;
            end
            if (!busy) begin
                if (direction_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = direction_q.pop_front();
                    i_valid <= 1'b1;
                    i_dir_x <= nxt.x;
                    i_dir_y <= nxt.y;
                    i_dir_z <= nxt.z;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_texel_addr want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (address_q.size() == 0) begin
                $display("%0t: unexpected word face %0d col %0d row %0d zero %0d", $time,
                         o_face, o_texel_col, o_texel_row, o_zero_direction);
                mismatch_count++;
            end else begin
                want = address_q.pop_front();
                check_field("face", want.face, o_face);
                check_field("texel_col", want.col, o_texel_col);
                check_field("texel_row", want.row, o_texel_row);
                check_field("zero_direction", want.zero, o_zero_direction);
            end
        end
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        int w;
        int h;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        push_dir(0, 0, 0);
        push_dir(32767, 0, 0);
        push_dir(-32768, 0, 0);
        push_dir(0, 32767, 0);
        push_dir(0, -32768, 0);
        push_dir(0, 0, 32767);
        push_dir(0, 0, -32768);
        push_dir(-32768, -32768, -32768);
        push_dir(32767, 32767, 32767);
        push_dir(100, 100, 5);
        push_dir(7, -7, 0);
        push_dir(100, -100, 100);
        push_dir(-500, 3, 500);
        push_dir(500, 500, 0);
        push_dir(1, 0, 0);
        push_dir(-1, 0, 0);
        push_dir(0, 1, -1);
        push_dir(32767, -32768, 12345);
        push_dir(-32768, 32767, -32767);
        push_dir(20000, -19999, 19999);
        push_dir(-3, 2, -2);
        push_dir(1, -1, 1);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            w = width_plan[p];
            h = height_plan[p];
            if (p >= 5) begin
                w = $urandom_range(cmta_pkg::MAX_FACE_SIZE, 1);
                h = $urandom_range((1 << cmta_pkg::SIZE_BITS) - 1);
            end
            write_reg(cmta_pkg::REG_FACE_WIDTH, cmta_pkg::CFG_DATA_BITS'(w));
            write_reg(cmta_pkg::REG_FACE_HEIGHT, cmta_pkg::CFG_DATA_BITS'(h));
            // unused index, must leave both sizes alone
            write_reg(cmta_pkg::CFG_INDEX_BITS'(
                          $urandom_range((1 << cmta_pkg::CFG_INDEX_BITS) - 1,
                                         cmta_pkg::REG_FACE_HEIGHT + 1)),
                      cmta_pkg::CFG_DATA_BITS'($urandom));
            @(negedge i_clk);
            send_idle_pct  = send_plan[p];
            recv_stall_pct = recv_plan[p];
            repeat (ITEMS_PER_PHASE) direction_q.push_back(random_direction());
            if (p == 4) hold_asks++;
        end

        settle();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
